FILE: src/pdc_pkg.sv
// shared constants and types for the pwm duty capture block
// no dependencies; imported by every module under src
`timescale 1ns / 1ps

package pdc_pkg;

    // width of the free-running timer and of one measured period
    localparam int unsigned TIMER_BITS = 16;
    localparam int unsigned TOTAL_BITS = TIMER_BITS + 1;

    // duty is 0..100, a percentage scale
    localparam int unsigned PCT_SCALE  = 100;
    localparam int unsigned DUTY_BITS  = 7;
    localparam int unsigned PROD_BITS  = TIMER_BITS + DUTY_BITS;

    localparam int unsigned BIT_CNT_BITS = $clog2(TIMER_BITS);
    localparam int unsigned DIV_CNT_BITS = $clog2(DUTY_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DIVIDE,
        ST_OUTPUT
    } pdc_state_t;

endpackage

FILE: src/pwm_duty_capture.sv
// Each accepted edge beat carries a timer capture; edges alternate rising, falling,
// starting with rising. From acceptance to the result register a beat passes the
// bit-serial period subtractor/adder, the registered on*100 step, the restoring
// divider and the handoffs between them. in_stall is high for that span. With the
// enable bit (written by cfg_write/cfg_data) low, beats are taken and dropped at
// once. A finished result waits in the output register while the next edge is
// worked on.
// top level; depends on pdc_pkg, pdc_serial_period, pdc_duty_div
`timescale 1ns / 1ps

module pwm_duty_capture (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pdc_pkg::TIMER_BITS-1:0]    capture_time,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pdc_pkg::TIMER_BITS-1:0]    on_period,
    output logic [pdc_pkg::TIMER_BITS-1:0]    off_period,
    output logic [pdc_pkg::TOTAL_BITS-1:0]    total_period,
    output logic [pdc_pkg::DUTY_BITS-1:0]     duty_percent,
    output logic                              duty_valid,
    output logic                              was_rising
);
    import pdc_pkg::*;

    pdc_state_t             state_reg, state_next;
    logic                   enable_reg, enable_next;
    logic                   expect_falling_reg, expect_falling_next;
    logic [TIMER_BITS-1:0]  last_capture_reg, last_capture_next;
    logic [TIMER_BITS-1:0]  high_time_reg, high_time_next;
    logic [TIMER_BITS-1:0]  low_time_reg, low_time_next;
    logic [TOTAL_BITS-1:0]  total_reg, total_next;
    logic                   rising_reg, rising_next;
    logic                   out_valid_reg, out_valid_next;

    logic [TIMER_BITS-1:0]  on_out_reg, off_out_reg;
    logic [TOTAL_BITS-1:0]  total_out_reg;
    logic [DUTY_BITS-1:0]   duty_out_reg;
    logic                   dvalid_out_reg, rising_out_reg;

    logic                   in_take;
    logic                   ser_start, ser_done;
    logic [TIMER_BITS-1:0]  ser_period;
    logic [TOTAL_BITS-1:0]  ser_total;
    logic                   div_start, div_done;
    logic [TIMER_BITS-1:0]  div_on;
    logic [DUTY_BITS-1:0]   div_quot;
    logic                   out_free;
    logic                   out_load;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    // on a rising edge the high time is the stored one, else the fresh period
    assign div_on   = rising_reg ? high_time_reg : ser_period;

    pdc_serial_period u_period (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (ser_start),
        .now_time     (capture_time),
        .last_time    (last_capture_reg),
        .other_period (expect_falling_reg ? low_time_reg : high_time_reg),
        .done         (ser_done),
        .period       (ser_period),
        .total        (ser_total)
    );

    pdc_duty_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .on_time  (div_on),
        .divisor  (ser_total),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next          = state_reg;
        enable_next         = cfg_write ? cfg_data : enable_reg;
        expect_falling_next = expect_falling_reg;
        last_capture_next   = last_capture_reg;
        high_time_next      = high_time_reg;
        low_time_next       = low_time_reg;
        total_next          = total_reg;
        rising_next         = rising_reg;
        out_valid_next      = out_valid_reg && out_stall;
        in_stall            = (state_reg != ST_IDLE);
        ser_start           = 1'b0;
        div_start           = 1'b0;
        out_load            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && enable_reg)
                begin
                    ser_start           = 1'b1;
                    rising_next         = !expect_falling_reg;
                    expect_falling_next = !expect_falling_reg;
                    last_capture_next   = capture_time;
                    state_next          = ST_PERIOD;
                end
            end
            ST_PERIOD:
            begin
                if (ser_done)
                begin
                    if (rising_reg)
                        low_time_next = ser_period;
                    else
                        high_time_next = ser_period;
                    total_next = ser_total;
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_OUTPUT;
                    end
                end
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            enable_reg         <= 1'b0;
            expect_falling_reg <= 1'b0;
            last_capture_reg   <= '0;
            high_time_reg      <= '0;
            low_time_reg       <= '0;
            total_reg          <= '0;
            rising_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            enable_reg         <= enable_next;
            expect_falling_reg <= in_take ? expect_falling_next : expect_falling_reg;
            last_capture_reg   <= in_take ? last_capture_next : last_capture_reg;
            high_time_reg      <= high_time_next;
            low_time_reg       <= low_time_next;
            total_reg          <= total_next;
            rising_reg         <= rising_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            on_out_reg     <= high_time_reg;
            off_out_reg    <= low_time_reg;
            total_out_reg  <= total_reg;
            dvalid_out_reg <= (total_reg != '0);
            duty_out_reg   <= (total_reg != '0) ? div_quot : '0;
            rising_out_reg <= rising_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign on_period    = on_out_reg;
    assign off_period   = off_out_reg;
    assign total_period = total_out_reg;
    assign duty_percent = duty_out_reg;
    assign duty_valid   = dvalid_out_reg;
    assign was_rising   = rising_out_reg;

endmodule

FILE: src/pdc_serial_period.sv
// bit-serial period unit: period = now - last and total = period + other
// one bit per cycle, lsb first; depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_serial_period (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pdc_pkg::TIMER_BITS-1:0]    now_time,
    input  logic [pdc_pkg::TIMER_BITS-1:0]    last_time,
    input  logic [pdc_pkg::TIMER_BITS-1:0]    other_period,
    output logic                              done,
    output logic [pdc_pkg::TIMER_BITS-1:0]    period,
    output logic [pdc_pkg::TOTAL_BITS-1:0]    total
);
    import pdc_pkg::*;

    logic [TIMER_BITS-1:0]   a_reg, a_next;
    logic [TIMER_BITS-1:0]   b_reg, b_next;
    logic [TIMER_BITS-1:0]   c_reg, c_next;
    logic [TIMER_BITS-1:0]   diff_reg, diff_next;
    logic [TIMER_BITS-1:0]   sum_reg, sum_next;
    logic                    borrow_reg, borrow_next;
    logic                    carry_reg, carry_next;
    logic [BIT_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic d_bit;
    logic s_bit;

    always_comb
    begin
        d_bit       = a_reg[0] ^ b_reg[0] ^ borrow_reg;
        s_bit       = d_bit ^ c_reg[0] ^ carry_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        diff_next   = diff_reg;
        sum_next    = sum_reg;
        borrow_next = borrow_reg;
        carry_next  = carry_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            a_next      = now_time;
            b_next      = last_time;
            c_next      = other_period;
            borrow_next = 1'b0;
            carry_next  = 1'b0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next      = a_reg >> 1;
            b_next      = b_reg >> 1;
            c_next      = c_reg >> 1;
            diff_next   = {d_bit, diff_reg[TIMER_BITS-1:1]};
            sum_next    = {s_bit, sum_reg[TIMER_BITS-1:1]};
            borrow_next = (~a_reg[0] & b_reg[0]) | (~(a_reg[0] ^ b_reg[0]) & borrow_reg);
            carry_next  = (d_bit & c_reg[0]) | (d_bit & carry_reg) | (c_reg[0] & carry_reg);
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_BITS'(TIMER_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        diff_reg   <= diff_next;
        sum_reg    <= sum_next;
        borrow_reg <= borrow_next;
        carry_reg  <= carry_next;
    end

    assign done   = done_reg;
    assign period = diff_reg;
    assign total  = {carry_reg, sum_reg};

endmodule

FILE: src/pdc_duty_div.sv
// duty unit: on * 100 in one registered step, then a restoring divide
// by the total, one quotient bit per cycle; depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_duty_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pdc_pkg::TIMER_BITS-1:0]    on_time,
    input  logic [pdc_pkg::TOTAL_BITS-1:0]    divisor,
    output logic                              done,
    output logic [pdc_pkg::DUTY_BITS-1:0]     quotient
);
    import pdc_pkg::*;

    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [TOTAL_BITS-1:0]   div_reg, div_next;
    logic [TOTAL_BITS-1:0]   rem_reg, rem_next;
    logic [DUTY_BITS-1:0]    low_reg, low_next;
    logic [DUTY_BITS-1:0]    quot_reg, quot_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    mul_reg, mul_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [TOTAL_BITS:0]     shifted;
    logic [TOTAL_BITS+1:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, low_reg[DUTY_BITS-1]};
        trial     = {1'b0, shifted} - {2'b00, div_reg};
        prod_next = prod_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        mul_next  = 1'b0;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = PROD_BITS'(on_time) * PROD_BITS'(PCT_SCALE);
            div_next  = divisor;
            mul_next  = 1'b1;
        end
        else if (mul_reg)
        begin
            // top bits start the remainder, already below the divisor
            rem_next  = TOTAL_BITS'(prod_reg[PROD_BITS-1:DUTY_BITS]);
            low_next  = prod_reg[DUTY_BITS-1:0];
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[TOTAL_BITS+1])
            begin
                rem_next  = trial[TOTAL_BITS-1:0];
                quot_next = {quot_reg[DUTY_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[TOTAL_BITS-1:0];
                quot_next = {quot_reg[DUTY_BITS-2:0], 1'b0};
            end
            low_next = low_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(DUTY_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mul_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            mul_reg  <= mul_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
